@@ rtl/qtg_pkg.sv @@
// Shared widths, register map and the coefficient bundle for the quartic trajectory generator.
// No dependencies.
`timescale 1ns / 1ps

package qtg_pkg;

	localparam int FRAC_BITS = 16;
	localparam int TIME_BITS = 24;

	localparam int VW    = 32;
	localparam int CW    = 48;
	localparam int ACC_W = 64;
	localparam int NL    = 4;
	localparam int NC    = 5;
	localparam int NREG  = 6;
	localparam int AW    = $clog2(NREG * 4);

	localparam int SAT_W = VW + TIME_BITS + 1;
	localparam int TB2_W = VW + TIME_BITS + 2;
	localparam int TT_W  = 2 * TIME_BITS;
	localparam int B1_W  = ((VW + 1 + FRAC_BITS) > SAT_W ? (VW + 1 + FRAC_BITS) : SAT_W) + 1;
	localparam int N_W   = (B1_W > TB2_W ? B1_W : TB2_W) + 2;
	localparam int DD_W  = N_W + 2 * FRAC_BITS;
	localparam int DV_W  = 3 * TIME_BITS + 2;

	localparam int S_TDATA_W = ((TIME_BITS + 7) / 8) * 8;
	localparam int M_TDATA_W = 4 * VW;
	localparam int M_TUSER_W = 2;

	localparam logic [TIME_BITS-1:0] DUR_RST = TIME_BITS'(65536);

	typedef enum logic [AW-3:0] {
		REG_START_POS = 0,
		REG_START_VEL = 1,
		REG_START_ACC = 2,
		REG_END_VEL   = 3,
		REG_END_ACC   = 4,
		REG_DURATION  = 5
	} reg_idx_t;

	typedef struct packed {
		logic signed [VW-1:0] sp;
		logic signed [VW-1:0] sv;
		logic signed [VW-1:0] sa;
		logic signed [VW-1:0] ev;
		logic signed [VW-1:0] ea;
		logic [TIME_BITS-1:0] dur;
	} cfg_t;

	// per lane Horner coefficients, leading term at index 0
	typedef struct packed {
		logic [NL-1:0][NC-1:0][ACC_W-1:0] c;
		logic                             clip;
		logic                             bad;
	} coef_t;

endpackage

@@ rtl/qtg_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on qtg_pkg for widths.
`timescale 1ns / 1ps

module qtg_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      go,
	input  logic [qtg_pkg::DD_W-1:0]  dividend,
	input  logic [qtg_pkg::DV_W-1:0]  divisor,
	output logic                      done,
	output logic [qtg_pkg::DD_W-1:0]  quot
);

	localparam int CNT_W = $clog2(qtg_pkg::DD_W + 1);

	logic [qtg_pkg::DV_W-1:0] rem_q;
	logic [qtg_pkg::DV_W-1:0] div_q;
	logic [qtg_pkg::DD_W-1:0] quot_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     run_q;
	logic                     done_q;
	logic [qtg_pkg::DV_W:0]   trial;
	logic                     qbit;

	always_comb begin
		trial = {rem_q, quot_q[qtg_pkg::DD_W-1]};
		qbit  = (trial >= {1'b0, div_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			div_q  <= '0;
			quot_q <= '0;
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				rem_q  <= '0;
				div_q  <= divisor;
				quot_q <= dividend;
				cnt_q  <= CNT_W'(qtg_pkg::DD_W);
				run_q  <= 1'b1;
			end else if (run_q) begin
				rem_q  <= qbit ? qtg_pkg::DV_W'(trial - {1'b0, div_q}) : qtg_pkg::DV_W'(trial);
				quot_q <= {quot_q[qtg_pkg::DD_W-2:0], qbit};
				cnt_q  <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

@@ rtl/qtg_coef.sv @@
// Coefficient sequencer: closed-form solve for the cubic and quartic terms after a register write.
// Depends on qtg_pkg and qtg_div.
`timescale 1ns / 1ps

module qtg_coef (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  qtg_pkg::cfg_t  cfg,
	output qtg_pkg::coef_t coef,
	output logic           busy
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_B1, ST_N,
		ST_D3, ST_W3, ST_D4, ST_W4, ST_FIN
	} state_t;

	localparam int TW = qtg_pkg::TIME_BITS;
	localparam int FB = qtg_pkg::FRAC_BITS;
	localparam int AW = qtg_pkg::ACC_W;

	state_t state_q;

	logic signed [qtg_pkg::SAT_W-1:0] sat_q;
	logic signed [qtg_pkg::TB2_W-1:0] tb2_q;
	logic [qtg_pkg::TT_W-1:0]         tt_q;
	logic [qtg_pkg::TT_W-1:0]         t3lo_q;
	logic [qtg_pkg::TT_W-1:0]         t3hi_q;
	logic signed [qtg_pkg::B1_W-1:0]  b1_q;
	logic signed [qtg_pkg::N_W-1:0]   n3_q;
	logic signed [qtg_pkg::N_W-1:0]   n4_q;
	logic [qtg_pkg::DV_W-1:0]         d3_q;
	logic [qtg_pkg::DV_W-1:0]         d4_q;
	logic signed [qtg_pkg::CW-1:0]    c3_q;
	logic signed [qtg_pkg::CW-1:0]    c4_q;
	logic                             clip_q;
	logic [qtg_pkg::NL-1:0][qtg_pkg::NC-1:0][AW-1:0] lanes_q;

	logic signed [qtg_pkg::VW:0]      b2;
	logic signed [qtg_pkg::VW:0]      dv;
	logic [qtg_pkg::N_W-1:0]          mag3;
	logic [qtg_pkg::N_W-1:0]          mag4;
	logic                             div_go;
	logic                             div_done;
	logic [qtg_pkg::DD_W-1:0]         div_dividend;
	logic [qtg_pkg::DV_W-1:0]         div_divisor;
	logic [qtg_pkg::DD_W-1:0]         div_quot;
	logic [qtg_pkg::CW:0]             clipped;
	logic signed [AW-1:0]             k0, k1, k2, k3, k4;
	logic signed [qtg_pkg::VW:0]      sa_rnd;

	function automatic logic [qtg_pkg::CW:0] clip48(input logic neg,
		input logic [qtg_pkg::DD_W-1:0] q);
		logic [qtg_pkg::DD_W-1:0] lim;
		logic [qtg_pkg::CW-1:0]   v;
		logic                     f;
		lim = qtg_pkg::DD_W'(1) << (qtg_pkg::CW - 1);
		if (neg) begin
			f = (q > lim);
			v = f ? {1'b1, {(qtg_pkg::CW-1){1'b0}}} : qtg_pkg::CW'(~q + 1'b1);
		end else begin
			f = (q >= lim);
			v = f ? {1'b0, {(qtg_pkg::CW-1){1'b1}}} : q[qtg_pkg::CW-1:0];
		end
		return {f, v};
	endfunction

	always_comb begin
		b2   = (qtg_pkg::VW+1)'(cfg.ea) - (qtg_pkg::VW+1)'(cfg.sa);
		dv   = (qtg_pkg::VW+1)'(cfg.ev) - (qtg_pkg::VW+1)'(cfg.sv);
		mag3 = n3_q[qtg_pkg::N_W-1] ? qtg_pkg::N_W'(-n3_q) : qtg_pkg::N_W'(n3_q);
		mag4 = n4_q[qtg_pkg::N_W-1] ? qtg_pkg::N_W'(-n4_q) : qtg_pkg::N_W'(n4_q);
		div_go       = (state_q == ST_D3) || (state_q == ST_D4);
		div_dividend = (state_q == ST_D4) ? (qtg_pkg::DD_W'(mag4) << (2 * FB))
		                                  : (qtg_pkg::DD_W'(mag3) << FB);
		div_divisor  = (state_q == ST_D4) ? d4_q : d3_q;
		clipped = clip48((state_q == ST_W4) ? n4_q[qtg_pkg::N_W-1] : n3_q[qtg_pkg::N_W-1],
			div_quot);
		// start accel / 2, rounded half up
		sa_rnd = ((qtg_pkg::VW+1)'(cfg.sa) + (qtg_pkg::VW+1)'(1)) >>> 1;
		k0 = AW'(cfg.sp);
		k1 = AW'(cfg.sv);
		k2 = AW'(sa_rnd);
		k3 = AW'(c3_q);
		k4 = AW'(c4_q);
	end

	qtg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sat_q   <= '0;
			tb2_q   <= '0;
			tt_q    <= '0;
			t3lo_q  <= '0;
			t3hi_q  <= '0;
			b1_q    <= '0;
			n3_q    <= '0;
			n4_q    <= '0;
			d3_q    <= '0;
			d4_q    <= '0;
			c3_q    <= '0;
			c4_q    <= '0;
			clip_q  <= 1'b0;
			lanes_q <= '0;
		end else if (start) begin
			state_q <= ST_M1;
			c3_q    <= '0;
			c4_q    <= '0;
			clip_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
				end
				ST_M1: begin
					sat_q   <= qtg_pkg::SAT_W'(cfg.sa) * qtg_pkg::SAT_W'($signed({1'b0, cfg.dur}));
					state_q <= ST_M2;
				end
				ST_M2: begin
					tb2_q   <= qtg_pkg::TB2_W'(b2) * qtg_pkg::TB2_W'($signed({1'b0, cfg.dur}));
					state_q <= ST_M3;
				end
				ST_M3: begin
					tt_q    <= qtg_pkg::TT_W'(cfg.dur) * qtg_pkg::TT_W'(cfg.dur);
					state_q <= ST_M4;
				end
				ST_M4: begin
					t3lo_q  <= qtg_pkg::TT_W'(tt_q[TW-1:0]) * qtg_pkg::TT_W'(cfg.dur);
					state_q <= ST_M5;
				end
				ST_M5: begin
					t3hi_q  <= qtg_pkg::TT_W'(tt_q[2*TW-1:TW]) * qtg_pkg::TT_W'(cfg.dur);
					state_q <= ST_B1;
				end
				ST_B1: begin
					b1_q    <= (qtg_pkg::B1_W'(dv) <<< FB) - qtg_pkg::B1_W'(sat_q);
					state_q <= ST_N;
				end
				ST_N: begin
					n3_q <= qtg_pkg::N_W'(b1_q) + (qtg_pkg::N_W'(b1_q) <<< 1)
						- qtg_pkg::N_W'(tb2_q);
					n4_q <= qtg_pkg::N_W'(tb2_q) - (qtg_pkg::N_W'(b1_q) <<< 1);
					d3_q <= qtg_pkg::DV_W'(tt_q) + (qtg_pkg::DV_W'(tt_q) << 1);
					d4_q <= (qtg_pkg::DV_W'(t3hi_q) << (TW + 2)) + (qtg_pkg::DV_W'(t3lo_q) << 2);
					state_q <= (cfg.dur == '0) ? ST_FIN : ST_D3;
				end
				ST_D3: state_q <= ST_W3;
				ST_W3: begin
					if (div_done) begin
						c3_q    <= clipped[qtg_pkg::CW-1:0];
						clip_q  <= clip_q | clipped[qtg_pkg::CW];
						state_q <= ST_D4;
					end
				end
				ST_D4: state_q <= ST_W4;
				ST_W4: begin
					if (div_done) begin
						c4_q    <= clipped[qtg_pkg::CW-1:0];
						clip_q  <= clip_q | clipped[qtg_pkg::CW];
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					lanes_q[0] <= {k0, k1, k2, k3, k4};
					lanes_q[1] <= {k1, k2 <<< 1, k3 + (k3 <<< 1), k4 <<< 2, AW'(0)};
					lanes_q[2] <= {k2 <<< 1, (k3 <<< 2) + (k3 <<< 1), (k4 <<< 3) + (k4 <<< 2),
						AW'(0), AW'(0)};
					lanes_q[3] <= {(k3 <<< 2) + (k3 <<< 1), (k4 <<< 4) + (k4 <<< 3),
						AW'(0), AW'(0), AW'(0)};
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign coef.c    = lanes_q;
	assign coef.clip = clip_q;
	assign coef.bad  = (cfg.dur == '0);
	assign busy      = (state_q != ST_IDLE) || start;

endmodule

@@ rtl/qtg_eval.sv @@
// Four-lane Horner evaluator: per step a partial-product stage and an add/clip stage.
// Depends on qtg_pkg.
`timescale 1ns / 1ps

module qtg_eval (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic [qtg_pkg::TIME_BITS-1:0]   in_t,
	input  logic                            busy,
	output logic                            in_ready,
	input  qtg_pkg::coef_t                  coef,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [qtg_pkg::M_TDATA_W-1:0]   out_data,
	output logic [qtg_pkg::M_TUSER_W-1:0]   out_user
);

	localparam int TW  = qtg_pkg::TIME_BITS;
	localparam int FB  = qtg_pkg::FRAC_BITS;
	localparam int AW  = qtg_pkg::ACC_W;
	localparam int NL  = qtg_pkg::NL;
	localparam int NS  = qtg_pkg::NC - 1;
	localparam int VW  = qtg_pkg::VW;
	localparam int PLW = AW / 2 + TW;
	localparam int PHW = AW / 2 + TW + 1;
	localparam int FW  = AW + TW + 1;
	localparam int SW  = AW + TW + 2;

	logic adv;

	logic          v_s0;
	logic [TW-1:0] t_s0;

	logic                    vm_s  [NS];
	logic [TW-1:0]           tm_s  [NS];
	logic                    fm_s  [NS];
	logic [PLW-1:0]          lo_m_s[NS][NL];
	logic signed [PHW-1:0]   hi_m_s[NS][NL];

	logic                    va_s  [NS];
	logic [TW-1:0]           ta_s  [NS];
	logic                    fa_s  [NS];
	logic signed [AW-1:0]    acc_a_s[NS][NL];

	logic                    vo_s;
	logic [qtg_pkg::M_TDATA_W-1:0] data_o_s;
	logic [qtg_pkg::M_TUSER_W-1:0] user_o_s;

	logic signed [FW-1:0]    full_c [NS][NL];
	logic signed [SW-1:0]    sum_c  [NS][NL];
	logic                    ovf_c  [NS][NL];
	logic signed [AW-1:0]    clip_c [NS][NL];
	logic                    any_ovf[NS];

	logic [VW-1:0]           res_c [NL];
	logic [NL-1:0]           ovf32;
	logic                    sat_c;

	assign adv      = !vo_s || out_ready;
	assign in_ready = adv && !busy;

	always_comb begin
		for (int k = 0; k < NS; k++) begin
			any_ovf[k] = 1'b0;
			for (int l = 0; l < NL; l++) begin
				full_c[k][l] = (FW'(hi_m_s[k][l]) <<< (AW / 2)) + FW'(lo_m_s[k][l]);
				sum_c[k][l]  = SW'(full_c[k][l] >>> FB) + SW'($signed(coef.c[l][k+1]));
				ovf_c[k][l]  = (sum_c[k][l][SW-1:AW-1] != {(SW-AW+1){sum_c[k][l][SW-1]}});
				clip_c[k][l] = ovf_c[k][l] ? {sum_c[k][l][SW-1], {(AW-1){~sum_c[k][l][SW-1]}}}
				                           : sum_c[k][l][AW-1:0];
				any_ovf[k]   = any_ovf[k] | ovf_c[k][l];
			end
		end
		for (int l = 0; l < NL; l++) begin
			ovf32[l] = (acc_a_s[NS-1][l][AW-1:VW-1] != {(AW-VW+1){acc_a_s[NS-1][l][AW-1]}});
			res_c[l] = ovf32[l] ? {acc_a_s[NS-1][l][AW-1], {(VW-1){~acc_a_s[NS-1][l][AW-1]}}}
			                    : acc_a_s[NS-1][l][VW-1:0];
		end
		sat_c = fa_s[NS-1] | (|ovf32) | coef.clip;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
			vo_s <= 1'b0;
			for (int k = 0; k < NS; k++) begin
				vm_s[k] <= 1'b0;
				va_s[k] <= 1'b0;
			end
		end else if (adv) begin
			v_s0 <= in_valid && in_ready;
			vm_s[0] <= v_s0;
			va_s[0] <= vm_s[0];
			for (int k = 1; k < NS; k++) begin
				vm_s[k] <= va_s[k-1];
				va_s[k] <= vm_s[k];
			end
			vo_s <= va_s[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s0 <= in_t;
			tm_s[0] <= t_s0;
			fm_s[0] <= 1'b0;
			for (int l = 0; l < NL; l++) begin
				lo_m_s[0][l] <= PLW'(coef.c[l][0][AW/2-1:0]) * PLW'(t_s0);
				hi_m_s[0][l] <= PHW'($signed(coef.c[l][0][AW-1:AW/2])) * PHW'($signed({1'b0, t_s0}));
			end
			for (int k = 1; k < NS; k++) begin
				tm_s[k] <= ta_s[k-1];
				fm_s[k] <= fa_s[k-1];
				for (int l = 0; l < NL; l++) begin
					lo_m_s[k][l] <= PLW'(acc_a_s[k-1][l][AW/2-1:0]) * PLW'(ta_s[k-1]);
					hi_m_s[k][l] <= PHW'($signed(acc_a_s[k-1][l][AW-1:AW/2]))
						* PHW'($signed({1'b0, ta_s[k-1]}));
				end
			end
			for (int k = 0; k < NS; k++) begin
				ta_s[k] <= tm_s[k];
				fa_s[k] <= fm_s[k] | any_ovf[k];
				for (int l = 0; l < NL; l++) begin
					acc_a_s[k][l] <= clip_c[k][l];
				end
			end
			if (coef.bad) begin
				data_o_s <= '0;
				user_o_s <= 2'b10;
			end else begin
				data_o_s <= {res_c[3], res_c[2], res_c[1], res_c[0]};
				user_o_s <= {1'b0, sat_c};
			end
		end
	end

	assign out_valid = vo_s;
	assign out_data  = data_o_s;
	assign out_user  = user_o_s;

endmodule

@@ rtl/quartic_trajectory_generator.sv @@
// Top level: APB register file, coefficient sequencer and pipelined Horner evaluator.
// Depends on qtg_pkg, qtg_coef and qtg_eval.
//
// channel   dir  handshake              word
// s_*       in   s_tvalid/s_tready      tdata: sample_time
// m_*       out  m_tvalid/m_tready      tdata: position, velocity, acceleration, jerk
//                                       tuser: saturated, bad_duration
// apb       in   psel/penable/pready    registers 0..5 at 4*i
//
// One word per cycle unless m stalls or a solve runs; stages: input, 4x multiply/add, output.
// After a register write s_tready stays low through start, five multiplies, two adds,
// two serial divisions and the load; the divisions are skipped when the duration is zero.
// arst_n clears valids, sequencer state, registers (duration: DUR_RST) and coefficients.
// A stall on m holds the whole pipeline; nothing is dropped.
`timescale 1ns / 1ps

module quartic_trajectory_generator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [qtg_pkg::S_TDATA_W-1:0]     s_tdata,  // [23:0] sample_time
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [qtg_pkg::M_TDATA_W-1:0]     m_tdata,  // position, velocity, acceleration, jerk
	output logic [qtg_pkg::M_TUSER_W-1:0]     m_tuser,  // [0] saturated, [1] bad_duration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [qtg_pkg::AW-1:0]            paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	qtg_pkg::cfg_t   cfg_q;
	qtg_pkg::coef_t  coef;
	qtg_pkg::reg_idx_t idx;
	logic            wr;
	logic            start;
	logic            busy;

	assign pready = 1'b1;
	assign idx    = qtg_pkg::reg_idx_t'(paddr[qtg_pkg::AW-1:2]);
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sp  <= '0;
			cfg_q.sv  <= '0;
			cfg_q.sa  <= '0;
			cfg_q.ev  <= '0;
			cfg_q.ea  <= '0;
			cfg_q.dur <= qtg_pkg::DUR_RST;
			start     <= 1'b0;
		end else begin
			start <= 1'b0;
			if (wr) begin
				start <= 1'b1;
				case (idx)
					qtg_pkg::REG_START_POS: cfg_q.sp  <= pwdata;
					qtg_pkg::REG_START_VEL: cfg_q.sv  <= pwdata;
					qtg_pkg::REG_START_ACC: cfg_q.sa  <= pwdata;
					qtg_pkg::REG_END_VEL:   cfg_q.ev  <= pwdata;
					qtg_pkg::REG_END_ACC:   cfg_q.ea  <= pwdata;
					qtg_pkg::REG_DURATION:  cfg_q.dur <= pwdata[qtg_pkg::TIME_BITS-1:0];
					default:                start     <= 1'b0;
				endcase
			end
		end
	end

	always_comb begin
		case (idx)
			qtg_pkg::REG_START_POS: prdata = cfg_q.sp;
			qtg_pkg::REG_START_VEL: prdata = cfg_q.sv;
			qtg_pkg::REG_START_ACC: prdata = cfg_q.sa;
			qtg_pkg::REG_END_VEL:   prdata = cfg_q.ev;
			qtg_pkg::REG_END_ACC:   prdata = cfg_q.ea;
			qtg_pkg::REG_DURATION:  prdata = 32'(cfg_q.dur);
			default:                prdata = '0;
		endcase
	end

	qtg_coef u_coef (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cfg    (cfg_q),
		.coef   (coef),
		.busy   (busy)
	);

	qtg_eval u_eval (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_t      (s_tdata[qtg_pkg::TIME_BITS-1:0]),
		.busy      (busy),
		.in_ready  (s_tready),
		.coef      (coef),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_user  (m_tuser)
	);

endmodule

@@ rtl/qtg_checker.sv @@
// Port-level checks for the quartic trajectory generator, bound to the top level.
// Depends on qtg_pkg and quartic_trajectory_generator.
`timescale 1ns / 1ps

module qtg_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [qtg_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [qtg_pkg::M_TUSER_W-1:0] m_tuser,
	input logic                          psel,
	input logic                          penable,
	input logic                          pwrite,
	input logic [qtg_pkg::AW-1:0]        paddr,
	input logic                          pready
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word changed while stalled");

	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(m_tvalid) |-> $past(m_tready))
		else $error("output word dropped");

	a_bad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata == '0 && !m_tuser[0])
		else $error("bad duration word not zeroed");

	a_solve: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready
		&& (paddr[qtg_pkg::AW-1:2] < (qtg_pkg::AW-2)'(qtg_pkg::NREG)) |=> !s_tready)
		else $error("input taken during coefficient solve");

endmodule

bind quartic_trajectory_generator qtg_checker u_qtg_checker (.*);

@@ tb/sv/tb_top.sv @@
// Self-checking bench for quartic_trajectory_generator: APB set-up of the profile,
// sample words on s, motion words on m checked against an in-bench coefficient solver.
// Depends on qtg_pkg and the generator RTL.
`timescale 1ns / 1ps

module tb_top;

	typedef logic signed [191:0] wide_t;

	typedef struct packed {
		logic signed [31:0] pos;
		logic signed [31:0] vel;
		logic signed [31:0] acc;
		logic signed [31:0] jrk;
		bit                 sat;
		bit                 bad;
	} motion_t;

	typedef enum int {ROW_CFG, ROW_PRED, ROW_ZERO, ROW_BAD} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		qtg_pkg::reg_idx_t  idx;
		logic [31:0]        val;
	} row_t;

	localparam int WATCHDOG = 5000;
	localparam int DRAIN    = 20;

	logic                          clk = 0;
	logic                          arst_n = 0;
	logic                          s_tvalid = 0;
	logic                          s_tready;
	logic [qtg_pkg::S_TDATA_W-1:0] s_tdata = '0;
	logic                          m_tvalid;
	logic                          m_tready = 0;
	logic [qtg_pkg::M_TDATA_W-1:0] m_tdata;
	logic [qtg_pkg::M_TUSER_W-1:0] m_tuser;
	logic                          psel = 0;
	logic                          penable = 0;
	logic                          pwrite = 0;
	logic [qtg_pkg::AW-1:0]        paddr = '0;
	logic [31:0]                   pwdata = '0;
	logic [31:0]                   prdata;
	logic                          pready;

	quartic_trajectory_generator dut (.*);

	always #5 clk = ~clk;

	// predictor state
	longint prof_reg [5];
	logic [qtg_pkg::TIME_BITS-1:0] prof_dur;
	longint coef [5];
	bit     coef_clip;

	motion_t motion_q [$];
	int  n_err, n_words, n_cfg, n_sat, n_bad, idle_cnt;
	bit  no_idle;

	function automatic longint clip_to(input wide_t v, input int bits, inout bit flag);
		wide_t maxv, minv;
		maxv = (wide_t'(1) <<< (bits - 1)) - 1;
		minv = -maxv - 1;
		if (v > maxv) begin
			flag = 1;
			return longint'(maxv);
		end
		if (v < minv) begin
			flag = 1;
			return longint'(minv);
		end
		return longint'(v);
	endfunction

	function automatic void solve_coefs();
		wide_t tw, b1, b2, n3, n4, q;
		longint x;
		coef[0] = prof_reg[qtg_pkg::REG_START_POS];
		coef[1] = prof_reg[qtg_pkg::REG_START_VEL];
		x = prof_reg[qtg_pkg::REG_START_ACC] + 1;
		coef[2] = x >>> 1;
		coef[3] = 0;
		coef[4] = 0;
		coef_clip = 0;
		if (prof_dur == 0)
			return;
		tw = 0;
		tw[qtg_pkg::TIME_BITS-1:0] = prof_dur;
		b1 = prof_reg[qtg_pkg::REG_END_VEL] - prof_reg[qtg_pkg::REG_START_VEL];
		b1 = b1 * 65536;
		q = prof_reg[qtg_pkg::REG_START_ACC];
		b1 = b1 - q * tw;
		b2 = prof_reg[qtg_pkg::REG_END_ACC];
		b2 = b2 - q;
		n3 = 3 * b1 - tw * b2;
		n4 = tw * b2 - 2 * b1;
		coef[3] = clip_to((n3 <<< qtg_pkg::FRAC_BITS) / (3 * tw * tw), qtg_pkg::CW, coef_clip);
		coef[4] = clip_to((n4 <<< (2 * qtg_pkg::FRAC_BITS)) / (4 * tw * tw * tw), qtg_pkg::CW,
			coef_clip);
	endfunction

	function automatic void set_prof_reg(input qtg_pkg::reg_idx_t idx, input logic [31:0] v);
		if (idx == qtg_pkg::REG_DURATION)
			prof_dur = v[qtg_pkg::TIME_BITS-1:0];
		else
			prof_reg[idx] = longint'(signed'(v));
		solve_coefs();
	endfunction

	function automatic logic signed [31:0] horner(input longint c [5], input int n,
			input logic [qtg_pkg::TIME_BITS-1:0] t, inout bit flag);
		wide_t tw, w;
		longint a;
		tw = 0;
		tw[qtg_pkg::TIME_BITS-1:0] = t;
		a = c[0];
		for (int i = 1; i < n; i++) begin
			w = a;
			w = (w * tw) >>> qtg_pkg::FRAC_BITS;
			w = w + c[i];
			a = clip_to(w, 64, flag);
		end
		return 32'(clip_to(wide_t'(a), 32, flag));
	endfunction

	function automatic motion_t predict_motion(input logic [qtg_pkg::TIME_BITS-1:0] t);
		motion_t m;
		longint cp [5], cv [5], ca [5], cj [5];
		bit s;
		m = '{default: 0};
		if (prof_dur == 0) begin
			m.bad = 1;
			return m;
		end
		s = coef_clip;
		cp = '{coef[4], coef[3], coef[2], coef[1], coef[0]};
		cv = '{4 * coef[4], 3 * coef[3], 2 * coef[2], coef[1], 0};
		ca = '{12 * coef[4], 6 * coef[3], 2 * coef[2], 0, 0};
		cj = '{24 * coef[4], 6 * coef[3], 0, 0, 0};
		m.pos = horner(cp, 5, t, s);
		m.vel = horner(cv, 4, t, s);
		m.acc = horner(ca, 3, t, s);
		m.jrk = horner(cj, 2, t, s);
		m.sat = s;
		return m;
	endfunction

	task automatic send_sample(input logic [qtg_pkg::TIME_BITS-1:0] t, input row_kind_t kind);
		motion_t m;
		forever begin
			@(negedge clk);
			if (!no_idle && $urandom_range(99) < 24) begin
				s_tvalid <= 0;
			end else begin
				s_tvalid <= 1;
				s_tdata  <= qtg_pkg::S_TDATA_W'(t);
				break;
			end
		end
		do @(posedge clk); while (!s_tready);
		m = '{default: 0};
		if (kind == ROW_BAD)
			m.bad = 1;
		else if (kind == ROW_PRED)
			m = predict_motion(t);
		motion_q.push_back(m);
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 0;
		while (motion_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	task automatic write_reg(input qtg_pkg::reg_idx_t idx, input logic [31:0] v);
		drain();
		psel    <= 1;
		pwrite  <= 1;
		penable <= 0;
		paddr   <= qtg_pkg::AW'(4 * int'(idx));
		pwdata  <= v;
		@(negedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		set_prof_reg(idx, v);
		n_cfg++;
		@(negedge clk);
		psel    <= 0;
		penable <= 0;
		pwrite  <= 0;
	endtask

	function automatic logic [qtg_pkg::TIME_BITS-1:0] rand_time();
		case ($urandom_range(3))
			0: return qtg_pkg::TIME_BITS'($urandom);
			1: return qtg_pkg::TIME_BITS'($urandom_range(131072));
			2: return qtg_pkg::TIME_BITS'($urandom_range(2 * 65536, 0));
			default: return $urandom_range(1) ? '1 : '0;
		endcase
	endfunction

	function automatic logic [31:0] rand_val(input bit wild);
		if (wild)
			return $urandom;
		case ($urandom_range(2))
			0: return 32'($signed($urandom_range(65536 * 8)) - 65536 * 4);
			1: return 32'($signed($urandom_range(65536)) - 32768);
			default: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
		endcase
	endfunction

	function automatic logic [31:0] rand_dur();
		case ($urandom_range(5))
			0: return 0;
			1: return 1;
			2: return $urandom;
			default: return $urandom_range(4 * 65536, 65536 / 4);
		endcase
	endfunction

	// directed rows
	row_t rows [] = '{
		'{ROW_ZERO, qtg_pkg::REG_START_POS, 32'h0000_0000},
		'{ROW_ZERO, qtg_pkg::REG_START_POS, 32'h00ff_ffff},
		'{ROW_ZERO, qtg_pkg::REG_START_POS, 32'h0001_0000},
		'{ROW_ZERO, qtg_pkg::REG_START_POS, 32'h0000_0001},
		'{ROW_CFG,  qtg_pkg::REG_DURATION,  32'h0000_0000},
		'{ROW_CFG,  qtg_pkg::REG_START_POS, 32'h7fff_ffff},
		'{ROW_BAD,  qtg_pkg::REG_START_POS, 32'h0000_0000},
		'{ROW_BAD,  qtg_pkg::REG_START_POS, 32'h00ff_ffff},
		'{ROW_BAD,  qtg_pkg::REG_START_POS, 32'h0000_8000},
		'{ROW_CFG,  qtg_pkg::REG_DURATION,  32'h0001_0000},
		'{ROW_CFG,  qtg_pkg::REG_START_VEL, 32'h0001_0000},
		'{ROW_CFG,  qtg_pkg::REG_START_ACC, 32'h0002_0000},
		'{ROW_CFG,  qtg_pkg::REG_END_VEL,   32'h0000_0000},
		'{ROW_CFG,  qtg_pkg::REG_END_ACC,   32'hfffe_0000},
		'{ROW_PRED, qtg_pkg::REG_START_POS, 32'h0000_0000},
		'{ROW_PRED, qtg_pkg::REG_START_POS, 32'h0000_8000},
		'{ROW_PRED, qtg_pkg::REG_START_POS, 32'h0001_0000},
		'{ROW_PRED, qtg_pkg::REG_START_POS, 32'h00ff_ffff},
		'{ROW_CFG,  qtg_pkg::REG_START_POS, 32'h8000_0000},
		'{ROW_CFG,  qtg_pkg::REG_START_VEL, 32'h8000_0000},
		'{ROW_CFG,  qtg_pkg::REG_START_ACC, 32'h7fff_ffff},
		'{ROW_CFG,  qtg_pkg::REG_END_VEL,   32'h7fff_ffff},
		'{ROW_CFG,  qtg_pkg::REG_END_ACC,   32'h8000_0000},
		'{ROW_CFG,  qtg_pkg::REG_DURATION,  32'h0000_0001},
		'{ROW_PRED, qtg_pkg::REG_START_POS, 32'h0000_0000},
		'{ROW_PRED, qtg_pkg::REG_START_POS, 32'h0000_0001},
		'{ROW_PRED, qtg_pkg::REG_START_POS, 32'h00ff_ffff},
		'{ROW_CFG,  qtg_pkg::REG_DURATION,  32'hffff_ffff},
		'{ROW_PRED, qtg_pkg::REG_START_POS, 32'h0000_0000},
		'{ROW_PRED, qtg_pkg::REG_START_POS, 32'h00ff_ffff}
	};

	always @(negedge clk)
		m_tready <= no_idle || ($urandom_range(99) >= 24);

	always @(posedge clk) begin
		motion_t e, a;
		if (m_tvalid && m_tready) begin
			a.pos = m_tdata[31:0];
			a.vel = m_tdata[63:32];
			a.acc = m_tdata[95:64];
			a.jrk = m_tdata[127:96];
			a.sat = m_tuser[0];
			a.bad = m_tuser[1];
			n_words++;
			n_sat += a.sat;
			n_bad += a.bad;
			if (motion_q.size() == 0) begin
				n_err++;
				if (n_err <= 10)
					$display("unexpected word pos=%h vel=%h acc=%h jrk=%h sat=%b bad=%b",
						a.pos, a.vel, a.acc, a.jrk, a.sat, a.bad);
			end else begin
				e = motion_q.pop_front();
				if (a != e) begin
					n_err++;
					if (n_err <= 10)
						$display("mismatch: exp %h %h %h %h %b %b, got %h %h %h %h %b %b",
							e.pos, e.vel, e.acc, e.jrk, e.sat, e.bad,
							a.pos, a.vel, a.acc, a.jrk, a.sat, a.bad);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WATCHDOG) begin
			$display("watchdog: %0d cycles without a word, %0d outstanding",
				idle_cnt, motion_q.size());
			$display("tb_top: done, errors");
			$finish;
		end
	end

	initial begin
		int n_items;
		n_err = 0;
		n_words = 0;
		n_cfg = 0;
		n_sat = 0;
		n_bad = 0;
		idle_cnt = 0;
		no_idle = 0;
		prof_reg = '{default: 0};
		prof_dur = qtg_pkg::DUR_RST;
		solve_coefs();
		repeat (9) @(negedge clk);
		arst_n <= 1;
		repeat (2) @(negedge clk);

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CFG)
				write_reg(rows[i].idx, rows[i].val);
			else
				send_sample(qtg_pkg::TIME_BITS'(rows[i].val), rows[i].kind);
		end

		n_items = 0;
		for (int ph = 0; ph < 12; ph++) begin
			bit wild;
			wild = (ph % 3 == 2);
			for (int r = 0; r < qtg_pkg::NREG; r++) begin
				if (r == int'(qtg_pkg::REG_DURATION))
					write_reg(qtg_pkg::reg_idx_t'(r), rand_dur());
				else
					write_reg(qtg_pkg::reg_idx_t'(r), rand_val(wild));
			end
			no_idle = (ph == 5);
			for (int k = 0; k < 125; k++) begin
				send_sample(rand_time(), ROW_PRED);
				n_items++;
				if (k == 60)
					drain();
			end
		end
		no_idle = 0;

		drain();
		$display("%0d directed rows, %0d random samples, %0d register writes", rows.size(),
			n_items, n_cfg);
		$display("%0d motion words checked, %0d saturated, %0d zero-duration, %0d mismatches",
			n_words, n_sat, n_bad, n_err);
		if (n_err == 0 && motion_q.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
